// File: sv/dense_layer_mac_top_assert.svh
// Assertion helpers for the RTL (used by dense_layer_mac_top); clocked on clk, quiet while rst_n is low.
`ifndef DENSE_LAYER_MAC_TOP_ASSERT_SVH
`define DENSE_LAYER_MAC_TOP_ASSERT_SVH

// same-cycle implication
`define DLM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dense_layer_mac: same-cycle check failed");

// next-cycle implication
`define DLM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dense_layer_mac: next-cycle check failed");

`endif

// File: sv/dlm_pkg.sv
`default_nettype none

package dlm_pkg;

  localparam int INPUTS     = 16;
  localparam int OUTPUTS    = 16;
  localparam int DATA_WIDTH = 16;
  localparam int FRAC       = 8;
  localparam int ACC_WIDTH  = 40;

  localparam int SLOT_W     = 8;
  localparam int OIDX_W     = 4;
  localparam int ACTION_W   = 2;
  localparam int PROD_W     = 2 * DATA_WIDTH;

  localparam int WGT_DEPTH  = INPUTS * OUTPUTS;
  localparam int WGT_AW     = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
  localparam int IDX_W      = (OUTPUTS > 1) ? $clog2(OUTPUTS) : 1;
  localparam int POS_W      = (INPUTS > 1) ? $clog2(INPUTS) : 1;

  localparam int IN_TDATA_W  = ((SLOT_W + DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_WIDTH + OIDX_W + 7) / 8) * 8;

  localparam logic [ACTION_W-1:0] ACT_WEIGHT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_BIAS   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DATA   = 2'd2;

  typedef struct packed {
    logic                         wgt_we;
    logic                         bias_we;
    logic [SLOT_W-1:0]            slot;
    logic signed [DATA_WIDTH-1:0] data;
    logic                         mac_go;
    logic                         seed;
    logic [POS_W-1:0]             pos;
    logic [IDX_W-1:0]             idx;
    logic                         rd_en;
  } dlm_ctl_t;

  typedef struct packed {
    logic                 busy;
    logic [ACC_WIDTH-1:0] acc;
  } dlm_sts_t;

endpackage

`default_nettype wire

// File: sv/dlm_core.sv
`default_nettype none

module dlm_core
  import dlm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire dlm_ctl_t ctl,
  output dlm_sts_t      sts
);

  logic        [DATA_WIDTH-1:0] wmem [WGT_DEPTH];
  logic        [DATA_WIDTH-1:0] bmem [OUTPUTS];
  logic        [ACC_WIDTH-1:0]  amem [OUTPUTS];

  logic signed [DATA_WIDTH-1:0] wrd_r;
  logic signed [DATA_WIDTH-1:0] brd_r;
  logic        [ACC_WIDTH-1:0]  ard_r;
  logic                         s1_vld_r;
  logic                         s1_seed_r;
  logic        [IDX_W-1:0]      s1_idx_r;

  logic signed [PROD_W-1:0]     prod_r;
  logic signed [DATA_WIDTH-1:0] bias_r;
  logic signed [ACC_WIDTH-1:0]  accq_r;
  logic                         s2_vld_r;
  logic                         s2_seed_r;
  logic        [IDX_W-1:0]      s2_idx_r;

  logic        [WGT_AW-1:0]     wrd_addr;
  logic signed [PROD_W-1:0]     prod_nxt;
  logic signed [ACC_WIDTH-1:0]  acc_base;
  logic signed [ACC_WIDTH-1:0]  acc_sum;

  // weight row for input position pos starts at pos*OUTPUTS
  assign wrd_addr = WGT_AW'(WGT_AW'(ctl.pos) * WGT_AW'(OUTPUTS) + WGT_AW'(ctl.idx));
  assign prod_nxt = PROD_W'(ctl.data) * PROD_W'(wrd_r);
  assign acc_base = s2_seed_r ? (ACC_WIDTH'(bias_r) <<< FRAC) : accq_r;
  assign acc_sum  = acc_base + ACC_WIDTH'(prod_r);

  // host writes to the weight and bias stores
  always_ff @(posedge clk) begin
    if (ctl.wgt_we && (int'(ctl.slot) < WGT_DEPTH)) begin
      wmem[WGT_AW'(ctl.slot)] <= ctl.data;
    end
    if (ctl.bias_we && (int'(ctl.slot) < OUTPUTS)) begin
      bmem[IDX_W'(ctl.slot)] <= ctl.data;
    end
  end

  // stage 0: memory reads
  always_ff @(posedge clk) begin
    if (ctl.mac_go) begin
      wrd_r <= wmem[wrd_addr];
      brd_r <= bmem[ctl.idx];
    end
    if (ctl.mac_go || ctl.rd_en) begin
      ard_r <= amem[ctl.idx];
    end
    s1_seed_r <= ctl.seed;
    s1_idx_r  <= ctl.idx;
  end

  // stage 1: multiply
  always_ff @(posedge clk) begin
    prod_r    <= prod_nxt;
    bias_r    <= brd_r;
    accq_r    <= ard_r;
    s2_seed_r <= s1_seed_r;
    s2_idx_r  <= s1_idx_r;
  end

  // stage 2: accumulate and write back
  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      amem[s2_idx_r] <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= ctl.mac_go;
      s2_vld_r <= s1_vld_r;
    end
  end

  assign sts.busy = s1_vld_r || s2_vld_r;
  assign sts.acc  = ard_r;

endmodule

`default_nettype wire

// File: sv/dense_layer_mac_top.sv
// Fully connected layer with bias, y[o] = bias[o] + sum_i x[i]*W[i][o], fixed point.
// Input stream (in_*): in_tuser selects the item kind; weight and bias items are
// stored at in_tdata's slot, data items carry one activation each. Results leave on
// out_*, one item per output neuron in order, out_tlast on the final one.
// A weight or bias write is done in its accept cycle. For an activation, the
// accept cycle is followed by a sweep of the accumulator memory, one neuron a cycle,
// through a single shared 16x16 multiplier with a read-multiply-writeback pipeline,
// which is then drained.
// After the INPUTS-th activation the block reads the accumulators back and emits
// OUTPUTS results, each through memory read, load and handshake states.
// One item is in work at a time; in_tready is low until it has finished,
// including while results are being emitted.
// A stall on out_tready holds the current result and the whole block.
// Reset clears the control state and the input position; the weight and bias
// stores are not cleared and must be written before use.
// Result = accumulator >> FRAC (floor), wrapped to 16 bits.
`default_nettype none
`include "dense_layer_mac_top_assert.svh"

module dense_layer_mac_top
  import dlm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // slot[7:0], value[23:8]
  input  wire logic [ACTION_W-1:0]    in_tuser,   // action[1:0]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // result_value[15:0], output_index[19:16]
  output logic                        out_tlast   // last_output
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_LD    = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(OUTPUTS - 1);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(INPUTS - 1);

  logic [2:0]                  state_r, state_nxt;
  logic [POS_W-1:0]            pos_r, pos_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic signed [DATA_WIDTH-1:0] x_r, x_nxt;
  logic                        seed_r, seed_nxt;
  logic                        out_vld_r, out_vld_nxt;
  logic [DATA_WIDTH-1:0]       out_data_r, out_data_nxt;
  logic [OIDX_W-1:0]           out_idx_r, out_idx_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        in_acc;
  logic [SLOT_W-1:0]           in_slot;
  logic signed [DATA_WIDTH-1:0] in_value;
  dlm_ctl_t                    core_ctl;
  dlm_sts_t                    core_sts;

  assign in_slot  = in_tdata[SLOT_W-1:0];
  assign in_value = in_tdata[SLOT_W +: DATA_WIDTH];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc   = in_tvalid && in_tready;

  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    idx_nxt      = idx_r;
    x_nxt        = x_r;
    seed_nxt     = seed_r;
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    out_idx_nxt  = out_idx_r;
    out_last_nxt = out_last_r;

    core_ctl         = '0;
    core_ctl.slot    = in_slot;
    core_ctl.data    = (state_r == ST_IDLE) ? in_value : x_r;
    core_ctl.pos     = pos_r;
    core_ctl.idx     = idx_r;
    core_ctl.seed    = seed_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_tuser)
            ACT_WEIGHT: core_ctl.wgt_we = 1'b1;
            ACT_BIAS:   core_ctl.bias_we = 1'b1;
            ACT_DATA: begin
              x_nxt     = in_value;
              seed_nxt  = (pos_r == '0);
              idx_nxt   = '0;
              state_nxt = ST_MAC;
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        core_ctl.mac_go = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!core_sts.busy) begin
          idx_nxt = '0;
          if (pos_r == LAST_POS) begin
            pos_nxt   = '0;
            state_nxt = ST_RD;
          end else begin
            pos_nxt   = pos_r + 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RD: begin
        core_ctl.rd_en = 1'b1;
        state_nxt      = ST_LD;
      end
      ST_LD: begin
        out_data_nxt = core_sts.acc[FRAC +: DATA_WIDTH];
        out_idx_nxt  = OIDX_W'(idx_r);
        out_last_nxt = (idx_r == LAST_IDX);
        out_vld_nxt  = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) begin
          out_vld_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pos_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    x_r        <= x_nxt;
    seed_r     <= seed_nxt;
    out_data_r <= out_data_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  dlm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (core_ctl),
    .sts   (core_sts)
  );

  assign out_tvalid = out_vld_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_TDATA_W'({out_idx_r, out_data_r});

  `DLM_ASSERT_IMP(a_idle_pipe_empty, in_tready, !core_sts.busy)
  `DLM_ASSERT_IMP(a_valid_only_out, out_tvalid, state_r == ST_OUT)
  `DLM_ASSERT_NXT(a_sweep_end, (state_r == ST_MAC) && (idx_r == LAST_IDX), (state_r == ST_DRAIN) && core_sts.busy)
  `DLM_ASSERT_NXT(a_vector_done, out_tvalid && out_tready && out_tlast, (state_r == ST_IDLE) && (pos_r == '0))

endmodule

`default_nettype wire

// File: bench/tb_dense_layer_mac_top.sv
`timescale 1ns / 1ps

module tb_dense_layer_mac_top;
  import dlm_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 60;

  typedef struct {
    logic [DATA_WIDTH-1:0] result_value;
    logic [OIDX_W-1:0]     output_index;
    logic                  last_output;
  } neuron_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;   // slot[7:0], value[23:8]
  logic [ACTION_W-1:0] in_tuser = '0;     // action[1:0]
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;      // result_value[15:0], output_index[19:16]
  logic out_tlast;                        // last_output

  // predictor state
  logic signed [DATA_WIDTH-1:0] weight_mem [WGT_DEPTH];
  logic signed [DATA_WIDTH-1:0] bias_mem [OUTPUTS];
  logic signed [ACC_WIDTH-1:0] acc_mem [OUTPUTS];
  int input_pos = 0;
  neuron_result_t pending_neuron_results [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int cycle_count = 0;

  dense_layer_mac_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_dense_layer_mac_top: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    neuron_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_neuron_results.size() == 0) begin
        $error("unexpected result item: result_value %0d output_index %0d",
               $signed(out_tdata[15:0]), out_tdata[19:16]);
        error_count++;
      end else begin
        exp_r = pending_neuron_results.pop_front();
        if (out_tdata[15:0] !== exp_r.result_value) begin
          $error("result_value: expected %0d, actual %0d",
                 $signed(exp_r.result_value), $signed(out_tdata[15:0]));
          error_count++;
        end
        if (out_tdata[19:16] !== exp_r.output_index) begin
          $error("output_index: expected %0d, actual %0d",
                 exp_r.output_index, out_tdata[19:16]);
          error_count++;
        end
        if (out_tlast !== exp_r.last_output) begin
          $error("last_output: expected %0d, actual %0d", exp_r.last_output, out_tlast);
          error_count++;
        end
      end
    end
  end

  task automatic update_layer_model(input logic [ACTION_W-1:0] action,
                                    input logic [SLOT_W-1:0] slot,
                                    input logic signed [DATA_WIDTH-1:0] value);
    logic signed [ACC_WIDTH-1:0] seed_val;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_WIDTH-1:0] scaled;
    neuron_result_t r;
    int j;
    case (action)
      ACT_WEIGHT: begin
        if (slot < WGT_DEPTH) weight_mem[slot] = value;
      end
      ACT_BIAS: begin
        if (slot < OUTPUTS) bias_mem[slot] = value;
      end
      ACT_DATA: begin
        if (input_pos == 0) begin
          // bias lined up with the product scale
          for (j = 0; j < OUTPUTS; j++) begin
            seed_val = bias_mem[j];
            acc_mem[j] = seed_val <<< FRAC;
          end
        end
        for (j = 0; j < OUTPUTS; j++) begin
          prod = value * weight_mem[input_pos * OUTPUTS + j];
          acc_mem[j] = acc_mem[j] + prod;
        end
        input_pos++;
        if (input_pos == INPUTS) begin
          input_pos = 0;
          for (j = 0; j < OUTPUTS; j++) begin
            scaled = acc_mem[j] >>> FRAC;
            r.result_value = scaled[DATA_WIDTH-1:0];
            r.output_index = OIDX_W'(j);
            r.last_output = (j == OUTPUTS - 1);
            pending_neuron_results.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input logic [ACTION_W-1:0] action,
                           input logic [SLOT_W-1:0] slot,
                           input logic signed [DATA_WIDTH-1:0] value);
    in_tvalid <= 1'b1;
    in_tuser <= action;
    in_tdata <= {value, slot};
    do @(posedge clk); while (!in_tready);
    update_layer_model(action, slot, value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (pending_neuron_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [DATA_WIDTH-1:0] rand_sample();
    case ($urandom_range(3))
      0: rand_sample = DATA_WIDTH'($urandom_range(65535));
      1, 2: rand_sample = DATA_WIDTH'(int'($urandom_range(2047)) - 1024);
      default: rand_sample = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  // every entry gets written before any activation reads it
  task automatic test_load_stores();
    int k;
    for (k = 0; k < WGT_DEPTH; k++) begin
      if (k < OUTPUTS) send_item(ACT_WEIGHT, SLOT_W'(k), 16'sh7fff);
      else if (k < 2 * OUTPUTS) send_item(ACT_WEIGHT, SLOT_W'(k), 16'sh8000);
      else send_item(ACT_WEIGHT, SLOT_W'(k), rand_sample());
    end
    send_item(ACT_BIAS, 8'd0, 16'sh7fff);
    send_item(ACT_BIAS, 8'd1, 16'sh8000);
    for (k = 2; k < OUTPUTS; k++) send_item(ACT_BIAS, SLOT_W'(k), rand_sample());
    wait_results_drained();
  endtask

  // out-of-range bias slots, the unused action, then a vector led by edge values
  task automatic test_directed_vector();
    int k;
    send_item(ACT_BIAS, 8'd16, 16'sh1234);
    send_item(ACT_BIAS, 8'd255, 16'sh8000);
    send_item(ACT_NONE, 8'hff, 16'shffff);
    send_item(ACT_NONE, 8'h00, 16'sh0000);
    send_item(ACT_DATA, 8'hff, 16'sh7fff);
    send_item(ACT_DATA, 8'h00, 16'sh8000);
    send_item(ACT_DATA, 8'h00, 16'sh8000);
    send_item(ACT_DATA, 8'h00, 16'sh0000);
    send_item(ACT_DATA, 8'h00, 16'sh0001);
    send_item(ACT_DATA, 8'h00, 16'shffff);
    send_item(ACT_DATA, 8'h00, 16'sh0100);
    send_item(ACT_DATA, 8'h00, 16'shff00);
    for (k = 8; k < INPUTS; k++) send_item(ACT_DATA, SLOT_W'($urandom), rand_sample());
    wait_results_drained();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int item_count);
    int sent;
    int pick;
    logic [SLOT_W-1:0] bias_slot;
    sent = 0;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < item_count) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_item(ACT_DATA, SLOT_W'($urandom), rand_sample());
        sent++;
      end else if (pick < 80) begin
        send_item(ACT_WEIGHT, SLOT_W'($urandom_range(WGT_DEPTH - 1)), rand_sample());
        sent++;
      end else if (pick < 90) begin
        bias_slot = $urandom_range(1) ? SLOT_W'($urandom_range(31)) : SLOT_W'($urandom);
        send_item(ACT_BIAS, bias_slot, rand_sample());
        if (bias_slot < OUTPUTS) sent++;
      end else begin
        send_item(ACT_NONE, SLOT_W'($urandom), rand_sample());
      end
    end
    // hold the sender off until everything owed has come back
    wait_results_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_stores();
    test_directed_vector();
    test_random_traffic(0, 0, 50);
    test_random_traffic(49, 0, 50);
    test_random_traffic(0, 49, 50);
    test_random_traffic(37, 37, 50);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_dense_layer_mac_top: done, clean");
    end else begin
      $display("tb_dense_layer_mac_top: done, errors");
    end
    $finish;
  end

endmodule
